FILE: src/bfp_pkg.sv
// Shared constants and types for the MSB-first bit field packer.
package bfp_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int FIELD_LIMIT = 32;
  localparam int BYTE_BITS = 8;
  localparam int ACC_BITS = MAX_FIELD_BITS + BYTE_BITS;
  // Widest value a pack step can build: seven pending bits plus one full field.
  localparam int PACK_BITS = FIELD_LIMIT + BYTE_BITS - 1;
  localparam int ACC_W = (ACC_BITS > PACK_BITS) ? ACC_BITS : PACK_BITS;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int MAX_RES = PACK_BITS / BYTE_BITS;
  localparam int RCNT_W = $clog2(MAX_RES + 1);
  localparam int RIDX_W = $clog2(MAX_RES);

  localparam logic [1:0] FUNC_FIELD = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_WIDTH = 3'd1;
  localparam logic [2:0] ERR_SHORT = 3'd2;
  localparam logic [2:0] ERR_FULL  = 3'd3;
  localparam logic [2:0] ERR_MODE  = 3'd4;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  typedef struct packed {
    logic [1:0]             func;
    logic [FIELD_LIMIT-1:0] field_value;
    logic [5:0]             field_bits;
    logic [BYTE_BITS-1:0]   load_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [BYTE_BITS-1:0]   byte_out;
    logic [FIELD_LIMIT-1:0] read_value;
    logic [2:0]             error_code;
  } res_t;

  typedef struct packed {
    logic [RCNT_W-1:0]      cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  typedef struct packed {
    logic             dir;
    logic [CNT_W-1:0] pend;
  } core_stat_t;

endpackage

FILE: src/bfp_core.sv
// Bit accumulator, direction register and the per-transaction pack/unpack logic.
module bfp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                step,
  input  bfp_pkg::item_t      item,
  output bfp_pkg::bundle_t    bundle,
  output bfp_pkg::core_stat_t stat
);
  import bfp_pkg::*;

  localparam logic [5:0] FB_LIMIT = 6'(FIELD_LIMIT);

  logic                   dir_r;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   bad_width;
  logic [FIELD_LIMIT-1:0] vmask;
  logic [ACC_W-1:0]       pack_acc;
  logic [CNT_W-1:0]       pack_tot;
  logic [ACC_W-1:0]       aligned;
  logic [ACC_W-1:0]       rd_full;
  logic [FIELD_LIMIT-1:0] rd_val;
  logic [BYTE_BITS-1:0]   flush_byte;

  assign bad_width = (item.field_bits == 6'd0) || (item.field_bits > FB_LIMIT);
  assign vmask     = ~({FIELD_LIMIT{1'b1}} << item.field_bits);
  assign pack_acc  = (acc_r << item.field_bits) | ACC_W'(item.field_value & vmask);
  assign pack_tot  = cnt_r + CNT_W'(item.field_bits);
  // Put the oldest pending bit at the top so completed bytes sit at fixed slices.
  assign aligned   = pack_acc << (CNT_W'(ACC_W) - pack_tot);
  assign rd_full   = acc_r >> (cnt_r - CNT_W'(item.field_bits));
  assign rd_val    = rd_full[FIELD_LIMIT-1:0] & vmask;
  assign flush_byte = acc_r[BYTE_BITS-1:0] << (CNT_W'(BYTE_BITS) - cnt_r);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    bundle  = '0;
    case (item.func)
      FUNC_FIELD: begin
        if (bad_width) begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_ERROR;
          bundle.res[0].error_code = ERR_WIDTH;
        end else if (dir_r == DIR_PACK) begin
          for (int j = 0; j < MAX_RES; j++) begin
            bundle.res[j].kind     = KIND_BYTE;
            bundle.res[j].byte_out = aligned[ACC_W-1-BYTE_BITS*j -: BYTE_BITS];
          end
          bundle.cnt = RCNT_W'(pack_tot / BYTE_BITS);
          acc_nxt    = pack_acc;
          cnt_nxt    = CNT_W'(pack_tot % BYTE_BITS);
        end else if (CNT_W'(item.field_bits) > cnt_r) begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_ERROR;
          bundle.res[0].error_code = ERR_SHORT;
        end else begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_FIELD;
          bundle.res[0].read_value = rd_val;
          cnt_nxt                  = cnt_r - CNT_W'(item.field_bits);
        end
      end
      FUNC_LOAD: begin
        if (dir_r != DIR_UNPACK) begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_ERROR;
          bundle.res[0].error_code = ERR_MODE;
        end else if (cnt_r > CNT_W'(ACC_BITS - BYTE_BITS)) begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_ERROR;
          bundle.res[0].error_code = ERR_FULL;
        end else begin
          acc_nxt = {acc_r[ACC_W-BYTE_BITS-1:0], item.load_byte};
          cnt_nxt = cnt_r + CNT_W'(BYTE_BITS);
        end
      end
      FUNC_FLUSH: begin
        if (dir_r != DIR_PACK) begin
          bundle.cnt               = RCNT_W'(1);
          bundle.res[0].kind       = KIND_ERROR;
          bundle.res[0].error_code = ERR_MODE;
        end else begin
          // An empty flush produces nothing but still clears the state.
          if (cnt_r != '0) begin
            bundle.cnt             = RCNT_W'(1);
            bundle.res[0].kind     = KIND_BYTE;
            bundle.res[0].byte_out = flush_byte;
          end
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      default: begin
        bundle.cnt               = RCNT_W'(1);
        bundle.res[0].kind       = KIND_ERROR;
        bundle.res[0].error_code = ERR_MODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_PACK;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.dir  = dir_r;
  assign stat.pend = cnt_r;

endmodule

FILE: src/bfp_obuf.sv
// Result register that holds one transaction's results and hands them out one per cycle while out_ready is high.
module bfp_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  bfp_pkg::bundle_t       bundle,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_byte_out,
  output logic [31:0]            out_read_value,
  output logic [2:0]             out_error_code,
  output logic                   out_last
);
  import bfp_pkg::*;

  logic              valid_r;
  logic [RIDX_W-1:0] idx_r;
  bundle_t           bnd_r;
  res_t              cur;
  logic              at_last;

  assign cur     = bnd_r.res[idx_r];
  assign at_last = (RCNT_W'(idx_r) + RCNT_W'(1)) == bnd_r.cnt;
  assign free    = !valid_r || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bundle;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = cur.kind;
  assign out_byte_out   = cur.byte_out;
  assign out_read_value = cur.read_value;
  assign out_error_code = cur.error_code;
  assign out_last       = at_last;

endmodule

FILE: src/msb_first_bit_field_packer.sv
// Top level of the MSB-first bit field packer: input register, core and result register.
//
// Usage: cfg_we/cfg_wdata set the direction (0 pack, 1 unpack) while the block is
// idle; every write clears the bit accumulator. Input transactions carry a function
// code with a field value and width or a stream byte; result transactions carry a
// packed byte, an unpacked field or an error code, with out_last on the final result
// of each input transaction.
// A transaction is first held in the input register, is processed by the core as it
// leaves it, and its first result is then offered from the result register.
// Throughput: one input transaction per cycle while each one produces at most one
// result and the receiver is ready. A field that completes several bytes (up to four)
// holds the result register until each byte is taken, which then bounds the rate.
// Transactions that produce no result (loads, short packs) never wait on the output.
// Reset (synchronous, rst_n low) selects pack mode and empties the accumulator and
// both registers. When the receiver stalls, the current result is held, and once the
// input register holds a transaction with results, in_ready falls until the result register drains.
module msb_first_bit_field_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_field_value,
  input  logic [5:0]  in_field_bits,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_out,
  output logic [31:0] out_read_value,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import bfp_pkg::*;

  logic       inq_valid_r;
  item_t      inq_r;
  bundle_t    bundle;
  core_stat_t stat;
  logic       buf_free;
  logic       advance;
  logic       has_res;

  assign has_res  = bundle.cnt != '0;
  assign advance  = inq_valid_r && (!has_res || buf_free);
  assign in_ready = !inq_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r.func        <= in_func;
      inq_r.field_value <= in_field_value;
      inq_r.field_bits  <= in_field_bits;
      inq_r.load_byte   <= in_load_byte;
    end
  end

  bfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (inq_r),
    .bundle    (bundle),
    .stat      (stat)
  );

  bfp_obuf u_obuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && has_res),
    .bundle         (bundle),
    .free           (buf_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte_out   (out_byte_out),
    .out_read_value (out_read_value),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  // In pack mode whole bytes always leave at once, so fewer than eight bits remain.
  a_pack_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.dir == DIR_PACK) |-> (stat.pend < CNT_W'(BYTE_BITS)))
    else $error("pack mode holds a full byte or more");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pend <= CNT_W'(ACC_BITS))
    else $error("accumulator count exceeds capacity");

  // A transaction with results must never overwrite results still being delivered.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && has_res) |-> buf_free)
    else $error("result register loaded while busy");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && inq_valid_r && has_res) |-> !in_ready)
    else $error("input taken while its results cannot be stored");
`endif

endmodule
